/* sv/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* sv/ssd_pkg.sv */
// types, codes and segment table of the seven-segment display link
package ssd_pkg;

    localparam logic [1:0] CMD_SHOW   = 2'd0;
    localparam logic [1:0] CMD_BRIGHT = 2'd1;
    localparam logic [1:0] CMD_ACK    = 2'd2;

    localparam logic [1:0] CFG_DATA_WRITE = 2'd0;
    localparam logic [1:0] CFG_ADDRESS    = 2'd1;
    localparam logic [1:0] CFG_CONTROL    = 2'd2;

    localparam logic [7:0] DATA_WRITE_RESET = 8'h40;
    localparam logic [7:0] ADDRESS_RESET    = 8'hC0;
    localparam logic [7:0] CONTROL_RESET    = 8'h88;

    // x / 10 == (x * 0xcccd) >> 19 for every 16-bit x
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_STOP  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] value;
        logic [3:0]  brightness;
        logic        ack_level;
    } in_t;

    typedef struct packed {
        kind_t      frame_kind;
        logic [7:0] data_byte;
        logic       done_res;
        logic       failed;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [7:0] data_write_command;
        logic [7:0] address_command;
        logic [7:0] display_control_command;
    } cfg_t;

    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } push_t;

    function automatic logic [7:0] seg_encode(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'h0:    s = 8'b00111111;
            4'h1:    s = 8'b00000110;
            4'h2:    s = 8'b01011011;
            4'h3:    s = 8'h4F;
            4'h4:    s = 8'h66;
            4'h5:    s = 8'h6D;
            4'h6:    s = 8'h7D;
            4'h7:    s = 8'h07;
            4'h8:    s = 8'h7F;
            4'h9:    s = 8'b01101111;
            4'hA:    s = 8'h77;
            4'hB:    s = 8'h7C;
            4'hC:    s = 8'h39;
            4'hD:    s = 8'h5E;
            4'hE:    s = 8'h79;
            default: s = 8'b01110001;
        endcase
        return s;
    endfunction

endpackage

/* sv/seven_seg_display_link.sv */
// top level of the seven-segment display link byte sequencer
//
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    in_data (in_t)
// out       out   out_valid / out_ready  out_data (out_t)
// cfg       in    cfg_write              cfg_index, cfg_data
//
// one input beat per cycle while in_ready is high; its results enter a four-entry queue the same edge
// a show loads a digit converter that does one divide by ten per cycle until all DIGIT_COUNT
// digits are stored; the acknowledge of the address byte waits for it
// in_ready needs room for two result beats, so a stalled output stops input
// reset clears the phase, queue pointers and registers to their defaults
module seven_seg_display_link
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             fire;
    logic             conv_load;
    logic             conv_busy;
    logic             addr_wait;
    logic             room_two;
    logic [POS_W-1:0] rd_idx;
    logic [3:0]       rd_digit;
    push_t            push;

    assign in_ready = room_two && !(conv_busy && addr_wait);
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_DATA_WRITE: cfg_next.data_write_command      = cfg_data;
                CFG_ADDRESS:    cfg_next.address_command         = cfg_data;
                CFG_CONTROL:    cfg_next.display_control_command = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_write_command      <= DATA_WRITE_RESET;
            cfg_reg.address_command         <= ADDRESS_RESET;
            cfg_reg.display_control_command <= CONTROL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ssd_digit_conv #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (conv_load),
        .value    (in_data.value),
        .rd_idx   (rd_idx),
        .rd_digit (rd_digit),
        .busy     (conv_busy)
    );

    ssd_sequencer #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .beat      (in_data),
        .cfg       (cfg_reg),
        .rd_digit  (rd_digit),
        .rd_idx    (rd_idx),
        .conv_load (conv_load),
        .addr_wait (addr_wait),
        .push      (push)
    );

    ssd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_valid && out_ready),
        .head      (out_data),
        .not_empty (out_valid),
        .room_two  (room_two)
    );

endmodule

/* sv/ssd_digit_conv.sv */
// binary to decimal digit store, one digit per cycle, least significant first
module ssd_digit_conv
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT = 4,
    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1,
    localparam int CNT_W = $clog2(DIGIT_COUNT + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [15:0]      value,
    input  logic [POS_W-1:0] rd_idx,
    output logic [3:0]       rd_digit,
    output logic             busy
);

    logic [15:0]      val_reg;
    logic [POS_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [3:0]       store_reg [DIGIT_COUNT];

    logic [31:0] prod;
    logic [12:0] quot;
    logic [15:0] times_ten;
    logic [15:0] rem;

    assign busy      = (cnt_reg != '0);
    assign prod      = val_reg * DIV10_MUL;
    assign quot      = prod[31:DIV10_SHIFT];
    assign times_ten = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem       = val_reg - times_ten;
    assign rd_digit  = store_reg[rd_idx];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = CNT_W'(DIGIT_COUNT);
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= value;
            idx_reg <= POS_W'(DIGIT_COUNT - 1);
        end
        else if (busy)
        begin
            store_reg[idx_reg] <= rem[3:0];
            val_reg            <= {3'b000, quot};
            idx_reg            <= idx_reg - 1'b1;
        end
    end

endmodule

/* sv/ssd_sequencer.sv */
// command and acknowledge sequencer producing framed byte beats
module ssd_sequencer
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT = 4,
    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1,
    localparam int CNT_W = $clog2(DIGIT_COUNT + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  in_t              beat,
    input  cfg_t             cfg,
    input  logic [3:0]       rd_digit,
    output logic [POS_W-1:0] rd_idx,
    output logic             conv_load,
    output logic             addr_wait,
    output push_t            push
);

`include "assert_macros.svh"

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_WDAA  = 5'b00010,
        PH_ADDR  = 5'b00100,
        PH_DIGIT = 5'b01000,
        PH_CTRL  = 5'b10000
    } phase_t;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] pos_next;
    logic             nz_reg;
    logic             nz_next;

    logic [CNT_W-1:0] pos_inc;
    logic             nz_now;
    logic [7:0]       seg_now;

    function automatic out_t mk(input kind_t k, input logic [7:0] b, input logic done,
                                input logic fail, input logic lst);
        out_t r;
        r.frame_kind = k;
        r.data_byte  = b;
        r.done_res   = done;
        r.failed     = fail;
        r.last       = lst;
        return r;
    endfunction

    assign pos_inc   = pos_reg + 1'b1;
    assign addr_wait = (phase_reg == PH_ADDR);
    assign rd_idx    = (phase_reg == PH_DIGIT) ? pos_inc[POS_W-1:0] : '0;
    assign nz_now    = nz_reg | (rd_digit != 4'd0);
    assign seg_now   = nz_now ? seg_encode(rd_digit) : 8'h00;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        nz_next     = nz_reg;
        conv_load   = 1'b0;
        push.count  = 2'd0;
        push.first  = mk(KIND_STOP, 8'h00, 1'b0, 1'b0, 1'b1);
        push.second = mk(KIND_STOP, 8'h00, 1'b0, 1'b0, 1'b1);
        if (fire)
        begin
            case (beat.command)
                CMD_SHOW:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        conv_load  = 1'b1;
                        pos_next   = '0;
                        nz_next    = 1'b0;
                        phase_next = PH_WDAA;
                        push.count = 2'd1;
                        push.first = mk(KIND_START, cfg.data_write_command, 1'b0, 1'b0, 1'b1);
                    end
                end
                CMD_BRIGHT:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next = PH_CTRL;
                        push.count = 2'd1;
                        push.first = mk(KIND_START,
                                        cfg.display_control_command | {4'h0, beat.brightness},
                                        1'b0, 1'b0, 1'b1);
                    end
                end
                CMD_ACK:
                begin
                    case (phase_reg)
                        PH_WDAA:
                        begin
                            if (beat.ack_level)
                            begin
                                phase_next = PH_IDLE;
                                push.count = 2'd1;
                                push.first = mk(KIND_STOP, 8'h00, 1'b1, 1'b1, 1'b1);
                            end
                            else
                            begin
                                phase_next  = PH_ADDR;
                                push.count  = 2'd2;
                                push.first  = mk(KIND_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
                                push.second = mk(KIND_START, cfg.address_command,
                                                 1'b0, 1'b0, 1'b1);
                            end
                        end
                        PH_ADDR:
                        begin
                            phase_next = PH_DIGIT;
                            pos_next   = '0;
                            nz_next    = nz_now;
                            push.count = 2'd1;
                            push.first = mk(KIND_BYTE, seg_now, 1'b0, 1'b0, 1'b1);
                        end
                        PH_DIGIT:
                        begin
                            push.count = 2'd1;
                            if (beat.ack_level)
                            begin
                                phase_next = PH_IDLE;
                                push.first = mk(KIND_STOP, 8'h00, 1'b1, 1'b1, 1'b1);
                            end
                            else if (pos_inc == CNT_W'(DIGIT_COUNT))
                            begin
                                phase_next = PH_IDLE;
                                pos_next   = '0;
                                push.first = mk(KIND_STOP, 8'h00, 1'b1, 1'b0, 1'b1);
                            end
                            else
                            begin
                                pos_next   = pos_inc;
                                nz_next    = nz_now;
                                push.first = mk(KIND_BYTE, seg_now, 1'b0, 1'b0, 1'b1);
                            end
                        end
                        PH_CTRL:
                        begin
                            phase_next = PH_IDLE;
                            push.count = 2'd1;
                            push.first = mk(KIND_STOP, 8'h00, 1'b1, beat.ack_level, 1'b1);
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            nz_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            nz_reg    <= nz_next;
        end
    end

    // a pair of beats only follows the data-write acknowledge
    `ASSERT_HOLDS(a_pair_from_wdaa, clk, rst_n,
                  (push.count == 2'd2) |-> (phase_reg == PH_WDAA),
                  "two beats pushed outside the data-write acknowledge")
    // digit position stays inside the display
    `ASSERT_NEVER(a_pos_range, clk, rst_n,
                  pos_reg >= CNT_W'(DIGIT_COUNT),
                  "digit position beyond the digit count")

endmodule

/* sv/ssd_result_fifo.sv */
// small result queue taking up to two beats per cycle
module ssd_result_fifo
    import ssd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output out_t  head,
    output logic  not_empty,
    output logic  room_two
);

`include "assert_macros.svh"

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    out_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign head       = mem_reg[rd_ptr_reg];
    assign not_empty  = (count_reg != '0);
    assign room_two   = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n,
                  count_reg > CNT_W'(FIFO_DEPTH),
                  "result queue overflow")
    `ASSERT_NEVER(a_no_underflow, clk, rst_n,
                  pop && (count_reg == '0),
                  "pop from an empty result queue")

endmodule

/* sim/tb_seven_seg_display_link.sv */
// self-checking testbench of the seven-segment display link byte sequencer
module tb_seven_seg_display_link;
    timeunit 1ns;
    timeprecision 1ps;

    import ssd_pkg::*;

    localparam int DIGITS = 4;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 305;
    localparam int SETTLE = 20;
    localparam int LONG_HOLD = 200;
    localparam int LIMIT = 3000;
    localparam int NO_NACK = -1;
    localparam int ACKS_PER_SHOW = DIGITS + 2;
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_WAIT_CMD,
        LINK_WAIT_ADDR,
        LINK_WAIT_DIGIT,
        LINK_WAIT_CTRL
    } link_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    logic [7:0] seg_lut [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    logic [7:0] reg_data_write = DATA_WRITE_RESET;
    logic [7:0] reg_address = ADDRESS_RESET;
    logic [7:0] reg_control = CONTROL_RESET;

    link_t link_phase = LINK_IDLE;
    logic [3:0] digit_val [DIGITS];
    int digit_pos = 0;
    logic lead_seen = 1'b0;

    in_t pend [$];
    out_t frames_due [$];
    out_t want_beat;

    logic in_took = 1'b0;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    int tx_wait = 0;
    int rx_wait = 0;
    int hold_gen = 0;
    int hold_seen = 0;
    int idle_cycles = 0;

    int errors = 0;
    int items_made = 0;
    int items_sent = 0;
    int beats_checked = 0;
    int shows_started = 0;
    int brights_started = 0;
    int nacks_seen = 0;
    int settings_used = 1;

    seven_seg_display_link #(.DIGIT_COUNT(DIGITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic out_t make_frame(kind_t kind, logic [7:0] data, logic done,
                                        logic fail, logic fin);
        out_t f;
        f.frame_kind = kind;
        f.data_byte = data;
        f.done_res = done;
        f.failed = fail;
        f.last = fin;
        return f;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_value();
        int r;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 10)
            v = 16'($urandom_range(0, 9));
        else if (r < 25)
            v = 16'($urandom_range(0, 999));
        else if (r < 35)
            v = 16'(10000 * $urandom_range(1, 6) + $urandom_range(0, 9));
        else if (r < 45)
        begin
            case ($urandom_range(0, 4))
                0: v = 16'd0;
                1: v = 16'd9999;
                2: v = 16'd10000;
                3: v = 16'hFFFF;
                default: v = 16'(1000 * $urandom_range(1, 9));
            endcase
        end
        else
            v = 16'($urandom);
        return v;
    endfunction

    task automatic push_digit();
        logic [3:0] d;
        d = digit_val[digit_pos];
        if (d != 4'd0)
            lead_seen = 1'b1;
        frames_due.push_back(make_frame(KIND_BYTE, lead_seen ? seg_lut[d] : 8'h00,
                                        1'b0, 1'b0, 1'b1));
    endtask

    task automatic predict_frames(input in_t it);
        int unsigned v;
        int i;
        case (it.command)
            CMD_SHOW:
                if (link_phase == LINK_IDLE)
                begin
                    v = it.value % (10 ** DIGITS);
                    for (i = DIGITS - 1; i >= 0; i--)
                    begin
                        digit_val[i] = 4'(v % 10);
                        v = v / 10;
                    end
                    digit_pos = 0;
                    lead_seen = 1'b0;
                    link_phase = LINK_WAIT_CMD;
                    shows_started++;
                    frames_due.push_back(make_frame(KIND_START, reg_data_write,
                                                    1'b0, 1'b0, 1'b1));
                end
            CMD_BRIGHT:
                if (link_phase == LINK_IDLE)
                begin
                    link_phase = LINK_WAIT_CTRL;
                    brights_started++;
                    frames_due.push_back(make_frame(KIND_START,
                                                    reg_control | {4'b0, it.brightness},
                                                    1'b0, 1'b0, 1'b1));
                end
            CMD_ACK:
                case (link_phase)
                    LINK_WAIT_CMD:
                        if (it.ack_level)
                        begin
                            link_phase = LINK_IDLE;
                            nacks_seen++;
                            frames_due.push_back(make_frame(KIND_STOP, 8'h00, 1'b1,
                                                            1'b1, 1'b1));
                        end
                        else
                        begin
                            link_phase = LINK_WAIT_ADDR;
                            frames_due.push_back(make_frame(KIND_STOP, 8'h00, 1'b0,
                                                            1'b0, 1'b0));
                            frames_due.push_back(make_frame(KIND_START, reg_address,
                                                            1'b0, 1'b0, 1'b1));
                        end
                    LINK_WAIT_ADDR:
                    begin
                        link_phase = LINK_WAIT_DIGIT;
                        digit_pos = 0;
                        push_digit();
                    end
                    LINK_WAIT_DIGIT:
                        if (it.ack_level)
                        begin
                            link_phase = LINK_IDLE;
                            nacks_seen++;
                            frames_due.push_back(make_frame(KIND_STOP, 8'h00, 1'b1,
                                                            1'b1, 1'b1));
                        end
                        else
                        begin
                            digit_pos++;
                            if (digit_pos >= DIGITS)
                            begin
                                link_phase = LINK_IDLE;
                                digit_pos = 0;
                                frames_due.push_back(make_frame(KIND_STOP, 8'h00, 1'b1,
                                                                1'b0, 1'b1));
                            end
                            else
                                push_digit();
                        end
                    LINK_WAIT_CTRL:
                    begin
                        link_phase = LINK_IDLE;
                        if (it.ack_level)
                            nacks_seen++;
                        frames_due.push_back(make_frame(KIND_STOP, 8'h00, 1'b1,
                                                        it.ack_level, 1'b1));
                    end
                    default: ;
                endcase
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // input and output beats sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_took = in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $display("%0t: result beat %h with nothing expected", $time, out_data);
                    errors++;
                end
                else
                begin
                    want_beat = frames_due.pop_front();
                    check_field("frame_kind", 8'(want_beat.frame_kind),
                                8'(out_data.frame_kind));
                    check_field("data_byte", want_beat.data_byte, out_data.data_byte);
                    check_field("done_res", 8'(want_beat.done_res), 8'(out_data.done_res));
                    check_field("failed", 8'(want_beat.failed), 8'(out_data.failed));
                    check_field("last", 8'(want_beat.last), 8'(out_data.last));
                    beats_checked++;
                end
            end
            if (in_took)
                predict_frames(in_data);
            if (in_took || (out_valid && out_ready) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_took)
                items_sent++;
            if (!in_valid || in_took)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (pend.size() > 0)
                begin
                    in_data <= pend.pop_front();
                    in_valid <= 1'b1;
                    tx_wait = (tx_steady || $urandom_range(0, 99) < 55) ? 0 : gap_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_gen != hold_seen)
        begin
            hold_seen = hold_gen;
            rx_wait = LONG_HOLD;
        end
        if (rx_wait > 0)
        begin
            rx_wait--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 25)
                rx_wait = gap_len();
        end
    end

    task automatic push_item(input logic [1:0] cmd, input logic [15:0] val,
                             input logic [3:0] lvl, input logic nack);
        in_t it;
        it.command = cmd;
        it.value = val;
        it.brightness = lvl;
        it.ack_level = nack;
        pend.push_back(it);
    endtask

    task automatic queue_ack(input logic nack);
        push_item(CMD_ACK, 16'($urandom), 4'($urandom), nack);
        items_made++;
    endtask

    task automatic queue_noise();
        logic [1:0] cmd;
        cmd = 2'($urandom_range(0, 3));
        push_item(cmd, 16'($urandom), 4'($urandom), 1'($urandom));
    endtask

    task automatic queue_show(input logic [15:0] val, input int nack_at,
                              input logic addr_lvl, input logic noisy);
        int k;
        push_item(CMD_SHOW, val, 4'($urandom), 1'($urandom));
        items_made++;
        for (k = 0; k < ACKS_PER_SHOW; k++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                queue_noise();
            if (k == 1)
                queue_ack(addr_lvl);
            else
                queue_ack(k == nack_at);
            if (k == nack_at && k != 1)
                break;
        end
    endtask

    task automatic queue_bright(input logic [3:0] lvl, input logic nack);
        push_item(CMD_BRIGHT, 16'($urandom), lvl, 1'($urandom));
        queue_ack(nack);
        items_made++;
    endtask

    task automatic wait_drained();
        while (!(pend.size() == 0 && !in_valid && frames_due.size() == 0))
            @(posedge clk);
    endtask

    task automatic drain_to_idle();
        wait_drained();
        while (link_phase != LINK_IDLE)
        begin
            queue_ack(1'b0);
            wait_drained();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_DATA_WRITE: reg_data_write = data;
            CFG_ADDRESS:    reg_address = data;
            CFG_CONTROL:    reg_control = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic program_phase(input int ph);
        case (ph)
            1:
            begin
                write_reg(CFG_DATA_WRITE, 8'h00);
                write_reg(CFG_ADDRESS, 8'h00);
                write_reg(CFG_CONTROL, 8'h00);
            end
            2:
            begin
                write_reg(CFG_DATA_WRITE, 8'hFF);
                write_reg(CFG_ADDRESS, 8'hFF);
                write_reg(CFG_CONTROL, 8'hFF);
            end
            default:
            begin
                write_reg(CFG_DATA_WRITE, 8'($urandom));
                write_reg(CFG_ADDRESS, 8'($urandom));
                write_reg(CFG_CONTROL, 8'($urandom));
            end
        endcase
        if (ph == 3)
            write_reg(CFG_UNUSED, 8'($urandom));
        settings_used++;
    endtask

    initial
    begin
        int ph;
        int r;
        int nack_at;
        int phase_start;
        logic paused;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
                program_phase(ph);
            tx_steady = (ph == 2 || ph == 3);
            rx_steady = (ph == 2);
            if (ph == 3)
                hold_gen++;
            if (ph == 0)
            begin
                // blank zero, truncated maximum, brightness extremes, early nack
                queue_show(16'd0, NO_NACK, 1'b0, 1'b0);
                queue_show(16'hFFFF, NO_NACK, 1'b1, 1'b0);
                queue_bright(4'hF, 1'b1);
                queue_bright(4'h0, 1'b0);
                queue_show(16'd1234, 0, 1'b0, 1'b0);
                queue_ack(1'b0);
                push_item(CMD_NONE, 16'hFFFF, 4'hF, 1'b1);
                // command while busy, then nack on the first digit
                push_item(CMD_SHOW, 16'd1005, 4'($urandom), 1'($urandom));
                queue_ack(1'b0);
                push_item(CMD_BRIGHT, 16'($urandom), 4'hA, 1'($urandom));
                queue_ack(1'b1);
                queue_ack(1'b1);
            end
            phase_start = items_made;
            paused = 1'b0;
            while (items_made - phase_start < ITEMS_PER_PHASE)
            begin
                if (ph == 4 && !paused && items_made - phase_start >= ITEMS_PER_PHASE / 2)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
                r = $urandom_range(0, 99);
                if (r < 62)
                begin
                    nack_at = ($urandom_range(0, 99) < 80) ? NO_NACK
                                                           : $urandom_range(0, ACKS_PER_SHOW - 1);
                    queue_show(pick_value(), nack_at, 1'($urandom_range(0, 1)), 1'b1);
                end
                else if (r < 85)
                    queue_bright(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                else
                    queue_noise();
            end
            drain_to_idle();
        end
        $display("sent %0d items: %0d shows, %0d brightness commands, %0d nacks",
                 items_sent, shows_started, brights_started, nacks_seen);
        $display("checked %0d result beats over %0d register settings",
                 beats_checked, settings_used);
        if (errors == 0 && frames_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
